// ===== rtl/spli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spli_pkg
// shared types and codes for the sorted point list insert unit
// ----------------------------------------------------------------------------
package spli_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // input beat payload
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [INDEX_W-1:0]        read_index;
  } in_item_t;

  // result beat payload
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
  } out_item_t;

  // broadcast from control to every cell
  typedef struct packed {
    logic               ins_en;
    logic               rd_en;
    point_t             key;
    logic [INDEX_W-1:0] read_index;
  } cell_cmd_t;

  // handed from each cell to its right neighbor
  typedef struct packed {
    logic   ins;
    point_t pt;
  } cell_link_t;

endpackage
`default_nettype wire

// ===== rtl/spli_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spli_in_if / spli_out_if
// valid/ready channels for input and result beats
// ----------------------------------------------------------------------------
interface spli_in_if;
  logic               valid;
  logic               ready;
  spli_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spli_out_if;
  logic                valid;
  logic                ready;
  spli_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/spli_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spli_cell
// one slot of the sorted chain: compares its point with the key, shifts
// right on insert and offers its point for an indexed read
// ----------------------------------------------------------------------------
module spli_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  wire logic                 clk,
  input  wire logic [CW-1:0]        count,
  input  wire spli_pkg::cell_cmd_t  cmd,
  input  wire spli_pkg::cell_link_t left,
  output spli_pkg::cell_link_t      right,
  output spli_pkg::point_t          rd_pt
);

  spli_pkg::point_t pt_r;
  spli_pkg::point_t pt_nxt;
  logic             occ;
  logic             le;
  logic             ins_here;
  logic             hit;

  assign occ = CW'(IDX) < count;

  // stored point ordered at or before the key, signed compare
  assign le = ($signed(pt_r.x) < $signed(cmd.key.x)) ||
              ((pt_r.x == cmd.key.x) && ($signed(pt_r.y) <= $signed(cmd.key.y)));

  // new point lands here or further left
  assign ins_here = !occ || !le;

  always_comb begin
    priority if (left.ins) begin
      pt_nxt = left.pt;
    end else if (ins_here) begin
      pt_nxt = cmd.key;
    end else begin
      pt_nxt = pt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      pt_r <= pt_nxt;
    end
  end

  assign right.ins = ins_here;
  assign right.pt  = pt_r;

  assign hit   = cmd.rd_en && (32'(cmd.read_index) == 32'(IDX));
  assign rd_pt = hit ? pt_r : '0;

endmodule
`default_nettype wire

// ===== rtl/sorted_point_list_insert_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_point_list_insert_unit
// bounded store of signed (x,y) points kept in ascending order
// ----------------------------------------------------------------------------
// Points live in a chain of CAPACITY cells held in sorted order. An insert is
// compared against every cell at once and each cell either keeps its point,
// takes its left neighbor's or takes the new one, so the whole shift is done
// in the cycle of the beat; a read picks one cell through an OR tree. Every
// input beat gives one result beat, registered, in the cycle after acceptance.
// The unit takes one beat per cycle while the result side keeps up; a result
// left waiting holds off the input until it is taken. Equal keys stay in
// arrival order. No clearing pass after reset: the store is empty at once.
module sorted_point_list_insert_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spli_in_if.sink     in_ch,
  spli_out_if.source  out_ch
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned LVLS = $clog2(CAPACITY);
  localparam int unsigned NP   = 1 << LVLS;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  spli_pkg::out_item_t out_r;
  spli_pkg::out_item_t out_nxt;

  logic                accept;
  logic                full;
  logic                rd_ok;
  spli_pkg::cell_cmd_t cmd;
  spli_pkg::cell_link_t links [CAPACITY+1];
  spli_pkg::point_t     tree [2*NP-1];

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign full         = count_r == CW'(CAPACITY);
  assign rd_ok        = (32'(in_ch.data.read_index) < 32'(count_r)) &&
                        (32'(in_ch.data.read_index) < 32'(CAPACITY));

  assign cmd.ins_en     = accept && (in_ch.data.mode == spli_pkg::MODE_INSERT) && !full;
  assign cmd.rd_en      = rd_ok;
  assign cmd.key.x      = in_ch.data.new_x;
  assign cmd.key.y      = in_ch.data.new_y;
  assign cmd.read_index = in_ch.data.read_index;

  assign links[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spli_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .count (count_r),
      .cmd   (cmd),
      .left  (links[i]),
      .right (links[i+1]),
      .rd_pt (tree[NP-1+i])
    );
  end

  for (genvar i = CAPACITY; i < NP; i++) begin : g_pad
    assign tree[NP-1+i] = '0;
  end

  // only the addressed cell drives a nonzero point
  for (genvar k = 0; k < NP - 1; k++) begin : g_or
    assign tree[k] = tree[2*k+1] | tree[2*k+2];
  end

  always_comb begin
    count_nxt      = count_r;
    out_nxt.status = spli_pkg::STAT_OK;
    out_nxt.out_x  = '0;
    out_nxt.out_y  = '0;
    unique case (in_ch.data.mode)
      spli_pkg::MODE_INSERT: begin
        if (full) begin
          out_nxt.status = spli_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      spli_pkg::MODE_READ: begin
        if (rd_ok) begin
          out_nxt.out_x = tree[0].x;
          out_nxt.out_y = tree[0].y;
        end else begin
          out_nxt.status = spli_pkg::STAT_RANGE;
        end
      end
      spli_pkg::MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_nxt.count = spli_pkg::COUNT_W'(count_nxt);
  end

  always_comb begin
    priority if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/spli_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spli_chk
// port-level checks for the sorted point list insert unit
// ----------------------------------------------------------------------------
module spli_chk #(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [spli_pkg::MODE_W-1:0]      in_mode,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [spli_pkg::STAT_W-1:0]      out_status,
  input wire logic [spli_pkg::COUNT_W-1:0]     out_count,
  input wire logic signed [spli_pkg::COORD_W-1:0] out_x,
  input wire logic signed [spli_pkg::COORD_W-1:0] out_y
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_count) && $stable(out_x) && $stable(out_y))
    else $error("result beat changed while stalled");

  // no input taken while a result is stuck
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // refused inserts and bad reads carry a zero point
  a_zero_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != spli_pkg::STAT_OK) |-> (out_x == '0) && (out_y == '0))
    else $error("nonzero point with error status");

  // clear empties the store in its own result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == spli_pkg::MODE_CLEAR) |=>
      out_valid && (out_count == '0) && (out_status == spli_pkg::STAT_OK))
    else $error("clear result wrong");

  // count bounded by capacity
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) || (32'(out_count) <= 32'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind sorted_point_list_insert_unit spli_chk #(
  .CAPACITY (CAPACITY)
) u_spli_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.data.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.data.status),
  .out_count  (out_ch.data.count),
  .out_x      (out_ch.data.out_x),
  .out_y      (out_ch.data.out_y)
);
`default_nettype wire
